// File: design/rs_erasure_codec_assert.svh
// Assertion macros used by the top-level codec module.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef RS_ERASURE_CODEC_ASSERT_SVH
`define RS_ERASURE_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSEC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rs_erasure_codec: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rs_erasure_codec: assertion failed");

`endif

// File: design/rsec_pkg.sv
package rsec_pkg;

    localparam int DATA_SHARES  = 3;
    localparam int TOTAL_SHARES = 5;

    localparam logic [7:0] POLY_LOW = 8'h1D;
    localparam logic [7:0] GF_ONE   = 8'h01;

    // Configuration register indexes.
    localparam logic [0:0] CFG_MODE = 1'b0;
    localparam logic [0:0] CFG_MASK = 1'b1;

    typedef logic [7:0]                    t_byte;
    typedef logic [TOTAL_SHARES-1:0][7:0]  t_row;
    typedef logic [TOTAL_SHARES-1:0]       t_mask;

    typedef struct packed {
        logic [7:0] share_in_0;
        logic [7:0] share_in_1;
        logic [7:0] share_in_2;
        logic [7:0] share_in_3;
        logic [7:0] share_in_4;
        logic       end_of_block;
    } t_in;

    typedef struct packed {
        logic [7:0] share_out_0;
        logic [7:0] share_out_1;
        logic [7:0] share_out_2;
        logic [7:0] share_out_3;
        logic [7:0] share_out_4;
        logic       status;
        logic       end_of_block_out;
    } t_out;

    // Per-configuration mixing matrix: output i = sum over k of coef[i][k] * share k.
    typedef struct packed {
        logic                         mode;
        logic                         err;
        logic [TOTAL_SHARES-1:0] [TOTAL_SHARES-1:0][7:0] coef;
    } t_cfg;

    // Control that travels with a column into the output stage.
    typedef struct packed {
        logic valid;
        logic err;
        logic eob;
    } t_stage;

    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    function automatic t_row row5(input t_byte k0, input t_byte k1, input t_byte k2,
                                  input t_byte k3, input t_byte k4);
        t_row r;
        r[0] = k0;
        r[1] = k1;
        r[2] = k2;
        r[3] = k3;
        r[4] = k4;
        return r;
    endfunction

    // The inverse of each surviving generator submatrix is folded into these rows,
    // so every erased share is a fixed linear combination of the first three survivors.
    function automatic t_cfg make_cfg(input logic mode, input t_mask mask);
        t_cfg       c;
        logic [2:0] cnt;
        cnt    = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]}
               + {2'b00, mask[3]} + {2'b00, mask[4]};
        c.mode = mode;
        c.err  = mode && (cnt > 3'd2);
        for (int i = 0; i < TOTAL_SHARES; i++) begin
            for (int k = 0; k < TOTAL_SHARES; k++) begin
                c.coef[i][k] = (i == k) ? GF_ONE : 8'h00;
            end
        end
        if (!mode) begin
            c.coef[3] = row5(8'h01, 8'h01, 8'h01, 8'h00, 8'h00);
            c.coef[4] = row5(8'h01, 8'h02, 8'h04, 8'h00, 8'h00);
        end else begin
            case (mask)
                5'b00001: c.coef[0] = row5(8'h00, 8'h01, 8'h01, 8'h01, 8'h00);
                5'b00010: c.coef[1] = row5(8'h01, 8'h00, 8'h01, 8'h01, 8'h00);
                5'b00100: c.coef[2] = row5(8'h01, 8'h01, 8'h00, 8'h01, 8'h00);
                5'b01000: c.coef[3] = row5(8'h01, 8'h01, 8'h01, 8'h00, 8'h00);
                5'b10000: c.coef[4] = row5(8'h01, 8'h02, 8'h04, 8'h00, 8'h00);
                5'b00011: begin
                    c.coef[0] = row5(8'h00, 8'h00, 8'h02, 8'hF5, 8'hF4);
                    c.coef[1] = row5(8'h00, 8'h00, 8'h03, 8'hF4, 8'hF4);
                end
                5'b00101: begin
                    c.coef[0] = row5(8'h00, 8'hF5, 8'h00, 8'hA6, 8'hA7);
                    c.coef[2] = row5(8'h00, 8'hF4, 8'h00, 8'hA7, 8'hA7);
                end
                5'b01001: begin
                    c.coef[0] = row5(8'h00, 8'h02, 8'h04, 8'h00, 8'h01);
                    c.coef[3] = row5(8'h00, 8'h03, 8'h05, 8'h00, 8'h01);
                end
                5'b10001: begin
                    c.coef[0] = row5(8'h00, 8'h01, 8'h01, 8'h01, 8'h00);
                    c.coef[4] = row5(8'h00, 8'h03, 8'h05, 8'h01, 8'h00);
                end
                5'b00110: begin
                    c.coef[1] = row5(8'h8F, 8'h00, 8'h00, 8'hF5, 8'h7A);
                    c.coef[2] = row5(8'h8E, 8'h00, 8'h00, 8'hF4, 8'h7A);
                end
                5'b01010: begin
                    c.coef[1] = row5(8'h8E, 8'h00, 8'h02, 8'h00, 8'h8E);
                    c.coef[3] = row5(8'h8F, 8'h00, 8'h03, 8'h00, 8'h8E);
                end
                5'b10010: begin
                    c.coef[1] = row5(8'h01, 8'h00, 8'h01, 8'h01, 8'h00);
                    c.coef[4] = row5(8'h03, 8'h00, 8'h06, 8'h02, 8'h00);
                end
                5'b01100: begin
                    c.coef[2] = row5(8'h47, 8'h8E, 8'h00, 8'h00, 8'h47);
                    c.coef[3] = row5(8'h46, 8'h8F, 8'h00, 8'h00, 8'h47);
                end
                5'b10100: begin
                    c.coef[2] = row5(8'h01, 8'h01, 8'h00, 8'h01, 8'h00);
                    c.coef[4] = row5(8'h05, 8'h06, 8'h00, 8'h04, 8'h00);
                end
                5'b11000: begin
                    c.coef[3] = row5(8'h01, 8'h01, 8'h01, 8'h00, 8'h00);
                    c.coef[4] = row5(8'h01, 8'h02, 8'h04, 8'h00, 8'h00);
                end
                // Nothing erased or too many erased: every share passes through.
                default: c.err = c.err;
            endcase
        end
        return c;
    endfunction

endpackage

// File: design/rsec_lane.sv
module rsec_lane
    import rsec_pkg::*;
(
    input  t_row  i_coef,
    input  t_row  i_share,
    output t_byte o_byte
);

    t_row w_prod;

    always_comb begin
        for (int k = 0; k < TOTAL_SHARES; k++) begin
            w_prod[k] = gf_mul(i_coef[k], i_share[k]);
        end
    end

    assign o_byte = w_prod[0] ^ w_prod[1] ^ w_prod[2] ^ w_prod[3] ^ w_prod[4];

endmodule

// File: design/rsec_cfg.sv
module rsec_cfg
    import rsec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    output t_cfg       o_cfg
);

    logic  r_mode;
    logic  n_mode;
    t_mask r_mask;
    t_mask n_mask;
    t_cfg  r_cfg;

    always_comb begin
        n_mode = r_mode;
        n_mask = r_mask;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: n_mode = i_cfg_data[0];
                CFG_MASK: n_mask = i_cfg_data;
                default:  n_mode = r_mode;
            endcase
        end
    end

    // The matrix is rebuilt from the next register values, so it is ready
    // in the same cycle the new setting is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_mask <= '0;
            r_cfg  <= make_cfg(1'b0, '0);
        end else begin
            r_mode <= n_mode;
            r_mask <= n_mask;
            r_cfg  <= make_cfg(n_mode, n_mask);
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/rsec_merge.sv
module rsec_merge
    import rsec_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_ctl,
    input  t_row   i_lane,
    input  logic   i_stall,
    output logic   o_adv,
    output logic   o_valid,
    output t_out   o_data
);

    logic r_valid;
    t_out r_data;
    t_out n_data;

    assign o_adv = !r_valid || !i_stall;

    always_comb begin
        n_data.share_out_0      = i_lane[0];
        n_data.share_out_1      = i_lane[1];
        n_data.share_out_2      = i_lane[2];
        n_data.share_out_3      = i_lane[3];
        n_data.share_out_4      = i_lane[4];
        n_data.status           = i_ctl.err;
        n_data.end_of_block_out = i_ctl.eob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_ctl.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: design/rs_erasure_codec.sv
// RS(5,3) erasure codec over GF(2^8), one byte column per beat.
// Input channel: i_valid / o_stall carry i_data (five share bytes plus an
// end-of-block marker). Output channel: o_valid / i_stall carry o_data (five
// share bytes, status, end-of-block copy). A beat moves on an edge where valid
// is high and stall is low.
// Configuration: i_cfg_we with i_cfg_idx 0 writes the mode (0 encode, 1 recover),
// index 1 writes the erased-share mask. Write only while the block is empty; the
// new setting applies to the very next input beat.
// Pipeline: a taken column is registered in the input stage, then the output
// stage. Throughput is one column per cycle while the receiver does not stall:
// five GF(2^8) lanes, each a row of five byte-by-byte multipliers, work on a
// column in parallel, with the per-setting mixing matrix held in registers.
// Reset clears both pipeline stages and sets encode mode with no erasures.
// When the receiver stalls, the output beat holds, the input stage keeps one more
// column, and o_stall rises only once both stages are full.
module rs_erasure_codec
    import rsec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_data
);

    `include "rs_erasure_codec_assert.svh"

    t_cfg   w_cfg;
    logic   r_a_valid;
    t_in    r_a_data;
    logic   w_adv_a;
    logic   w_adv_o;
    t_row   w_share;
    t_row   w_lane;
    t_stage w_ctl;

    rsec_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_adv_a = !r_a_valid || w_adv_o;
    assign o_stall = !w_adv_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a && i_valid) begin
            r_a_data <= i_data;
        end
    end

    always_comb begin
        w_share[0] = r_a_data.share_in_0;
        w_share[1] = r_a_data.share_in_1;
        w_share[2] = r_a_data.share_in_2;
        w_share[3] = r_a_data.share_in_3;
        w_share[4] = r_a_data.share_in_4;
    end

    for (genvar g = 0; g < TOTAL_SHARES; g++) begin : g_lane
        rsec_lane u_lane (
            .i_coef  (w_cfg.coef[g]),
            .i_share (w_share),
            .o_byte  (w_lane[g])
        );
    end

    always_comb begin
        w_ctl.valid = r_a_valid;
        w_ctl.err   = w_cfg.err;
        w_ctl.eob   = r_a_data.end_of_block;
    end

    rsec_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_lane  (w_lane),
        .i_stall (i_stall),
        .o_adv   (w_adv_o),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    `RSEC_ASSERT_NOW(a_stall_only_when_full, o_stall, r_a_valid && o_valid)
    `RSEC_ASSERT_NEXT(a_eob_follows, r_a_valid && w_adv_o,
        o_data.end_of_block_out == $past(r_a_data.end_of_block))
    `RSEC_ASSERT_NEXT(a_encode_parity, r_a_valid && w_adv_o && !w_cfg.mode,
        !o_data.status &&
        (o_data.share_out_3 == (o_data.share_out_0 ^ o_data.share_out_1 ^ o_data.share_out_2)))
    `RSEC_ASSERT_NEXT(a_error_passthrough, r_a_valid && w_adv_o && w_cfg.err,
        o_data.status && (o_data.share_out_3 == $past(r_a_data.share_in_3)) &&
        (o_data.share_out_4 == $past(r_a_data.share_in_4)))

endmodule

// File: test/rs_erasure_codec_test.sv
`timescale 1ns / 100ps

module rs_erasure_codec_test;

    import rsec_pkg::*;

    // Works out the expected share column for every accepted input beat and
    // compares it with what the codec delivers, in order.
    class rs_column_checker;
        logic  mode_reg;
        t_mask mask_reg;
        t_out  expected_columns[$];
        int    mismatches;

        function new();
            mode_reg   = 1'b0;
            mask_reg   = '0;
            mismatches = 0;
        endfunction

        function void set_register(input logic [0:0] idx, input logic [4:0] value);
            if (idx == CFG_MODE) begin
                mode_reg = value[0];
            end else if (idx == CFG_MASK) begin
                mask_reg = value;
            end
        endfunction

        function t_byte gf_times(input t_byte a, input t_byte b);
            t_byte acc;
            t_byte x;
            acc = '0;
            x   = a;
            for (int k = 0; k < 8; k++) begin
                if (b[k]) begin
                    acc = acc ^ x;
                end
                x = x[7] ? ((x << 1) ^ POLY_LOW) : (x << 1);
            end
            return acc;
        endfunction

        // The multiplicative group has order 255, so x^254 is the inverse.
        function t_byte gf_recip(input t_byte a);
            t_byte r;
            r = 8'h01;
            if (a == 8'h00) begin
                return 8'h00;
            end
            repeat (254) r = gf_times(r, a);
            return r;
        endfunction

        function t_byte gen_coef(input int row, input int col);
            if (row < DATA_SHARES) begin
                return (row == col) ? 8'h01 : 8'h00;
            end
            if (row == DATA_SHARES) begin
                return 8'h01;
            end
            return t_byte'(8'h01 << col);
        endfunction

        function t_out code_column(input logic md, input t_mask msk, input t_in c);
            t_byte sh[TOTAL_SHARES];
            t_byte res[TOTAL_SHARES];
            t_byte dat[DATA_SHARES];
            t_byte aug[DATA_SHARES][DATA_SHARES+1];
            t_byte ip;
            t_byte f;
            t_byte tmp;
            t_out  r;
            int    lost;
            int    n;
            int    piv;
            logic  bad;
            sh[0] = c.share_in_0;
            sh[1] = c.share_in_1;
            sh[2] = c.share_in_2;
            sh[3] = c.share_in_3;
            sh[4] = c.share_in_4;
            bad   = 1'b0;
            if (!md) begin
                for (int i = 0; i < TOTAL_SHARES; i++) begin
                    res[i] = '0;
                    for (int j = 0; j < DATA_SHARES; j++) begin
                        res[i] ^= gf_times(gen_coef(i, j), sh[j]);
                    end
                end
            end else begin
                lost = 0;
                for (int i = 0; i < TOTAL_SHARES; i++) begin
                    lost += msk[i];
                    res[i] = sh[i];
                end
                if (lost > TOTAL_SHARES - DATA_SHARES) begin
                    bad = 1'b1;
                end else if (lost > 0) begin
                    // Solve the first three surviving rows for the data bytes.
                    n = 0;
                    for (int i = 0; i < TOTAL_SHARES; i++) begin
                        if (!msk[i] && n < DATA_SHARES) begin
                            for (int j = 0; j < DATA_SHARES; j++) begin
                                aug[n][j] = gen_coef(i, j);
                            end
                            aug[n][DATA_SHARES] = sh[i];
                            n++;
                        end
                    end
                    for (int rr = 0; rr < DATA_SHARES; rr++) begin
                        piv = -1;
                        for (int i = rr; i < DATA_SHARES; i++) begin
                            if (piv < 0 && aug[i][rr] != 8'h00) begin
                                piv = i;
                            end
                        end
                        if (piv >= 0) begin
                            if (piv != rr) begin
                                for (int j = 0; j <= DATA_SHARES; j++) begin
                                    tmp          = aug[piv][j];
                                    aug[piv][j]  = aug[rr][j];
                                    aug[rr][j]   = tmp;
                                end
                            end
                            ip = gf_recip(aug[rr][rr]);
                            for (int j = 0; j <= DATA_SHARES; j++) begin
                                aug[rr][j] = gf_times(aug[rr][j], ip);
                            end
                            for (int i = 0; i < DATA_SHARES; i++) begin
                                f = aug[i][rr];
                                if (i != rr && f != 8'h00) begin
                                    for (int j = 0; j <= DATA_SHARES; j++) begin
                                        aug[i][j] ^= gf_times(f, aug[rr][j]);
                                    end
                                end
                            end
                        end
                    end
                    for (int j = 0; j < DATA_SHARES; j++) begin
                        dat[j] = aug[j][DATA_SHARES];
                    end
                    for (int i = 0; i < TOTAL_SHARES; i++) begin
                        if (msk[i]) begin
                            res[i] = '0;
                            for (int j = 0; j < DATA_SHARES; j++) begin
                                res[i] ^= gf_times(gen_coef(i, j), dat[j]);
                            end
                        end
                    end
                end
            end
            r.share_out_0      = res[0];
            r.share_out_1      = res[1];
            r.share_out_2      = res[2];
            r.share_out_3      = res[3];
            r.share_out_4      = res[4];
            r.status           = bad;
            r.end_of_block_out = c.end_of_block;
            return r;
        endfunction

        function void note_column(input t_in c);
            expected_columns.push_back(code_column(mode_reg, mask_reg, c));
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        function void compare_field(input string name, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
            if (act_v !== exp_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_column(input t_out got);
            t_out want;
            if (expected_columns.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected column, expected none, actual %h", $time, got);
                return;
            end
            want = expected_columns.pop_front();
            compare_field("share_out_0", want.share_out_0, got.share_out_0);
            compare_field("share_out_1", want.share_out_1, got.share_out_1);
            compare_field("share_out_2", want.share_out_2, got.share_out_2);
            compare_field("share_out_3", want.share_out_3, got.share_out_3);
            compare_field("share_out_4", want.share_out_4, got.share_out_4);
            compare_field("status", 8'(want.status), 8'(got.status));
            compare_field("end_of_block_out", 8'(want.end_of_block_out),
                          8'(got.end_of_block_out));
        endfunction
    endclass

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [0:0] i_cfg_idx  = CFG_MODE;
    logic [4:0] i_cfg_data = '0;
    logic       i_valid    = 1'b0;
    logic       o_stall;
    t_in        i_data     = '0;
    logic       o_valid;
    logic       i_stall    = 1'b0;
    t_out       o_data;

    rs_column_checker sb;

    int stall_style = 0;
    int style_left  = 0;

    rs_erasure_codec DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between free flow, light, heavy and near-total stalling.
    always @(posedge i_clk) begin
        if (style_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(20, 80);
        end else begin
            style_left <= style_left - 1;
        end
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= ($urandom_range(0, 7) == 0);
            default: i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_column(o_data);
        end
    end

    function automatic t_byte rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in col(input t_byte b0, input t_byte b1, input t_byte b2,
                                input t_byte b3, input t_byte b4, input logic eob);
        t_in c;
        c.share_in_0   = b0;
        c.share_in_1   = b1;
        c.share_in_2   = b2;
        c.share_in_3   = b3;
        c.share_in_4   = b4;
        c.end_of_block = eob;
        return c;
    endfunction

    // A valid codeword for the given data, with garbage in the erased positions.
    function automatic t_in codeword(input t_byte d0, input t_byte d1, input t_byte d2,
                                     input t_mask msk, input logic eob);
        t_in  c;
        t_out cw;
        cw = sb.code_column(1'b0, '0, col(d0, d1, d2, 8'h00, 8'h00, eob));
        c  = col(cw.share_out_0, cw.share_out_1, cw.share_out_2,
                 cw.share_out_3, cw.share_out_4, eob);
        if (msk[0]) c.share_in_0 = rand_byte();
        if (msk[1]) c.share_in_1 = rand_byte();
        if (msk[2]) c.share_in_2 = rand_byte();
        if (msk[3]) c.share_in_3 = rand_byte();
        if (msk[4]) c.share_in_4 = rand_byte();
        return c;
    endfunction

    function automatic t_in make_column(input t_mask msk, input logic noise);
        logic eob;
        eob = ($urandom_range(0, 5) == 0);
        if (noise) begin
            return col(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), eob);
        end
        return codeword(rand_byte(), rand_byte(), rand_byte(), msk, eob);
    endfunction

    // Mostly recoverable patterns, with an occasional arbitrary mask.
    function automatic t_mask pick_mask();
        int r;
        int a;
        int b;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end
        if (r <= 3) begin
            return t_mask'(1 << $urandom_range(0, 4));
        end
        if (r <= 8) begin
            a = $urandom_range(0, 4);
            b = $urandom_range(0, 3);
            if (b >= a) b++;
            return t_mask'((1 << a) | (1 << b));
        end
        return t_mask'($urandom_range(0, 31));
    endfunction

    task automatic send_column(input t_in c);
        i_valid <= 1'b1;
        i_data  <= c;
        do @(posedge i_clk); while (o_stall);
        sb.note_column(c);
    endtask

    task automatic idle_for(input int cycles);
        i_valid <= 1'b0;
        i_data  <= col(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                       1'($urandom_range(0, 1)));
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic md, input t_mask msk);
        logic [4:0] mode_word;
        mode_word = {4'($urandom_range(0, 15)), md};
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODE;
        i_cfg_data <= mode_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MASK;
        i_cfg_data <= msk;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(CFG_MODE, mode_word);
        sb.set_register(CFG_MASK, msk);
    endtask

    initial begin
        int    total;
        int    items;
        int    burst_left;
        logic  md;
        t_mask msk;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Encode mode straight out of reset; the upper parity inputs must not matter.
        send_column(col(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_column(col(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_column(col(8'h01, 8'h02, 8'h80, 8'hFF, 8'h00, 1'b0));
        send_column(col(8'h80, 8'h40, 8'hC3, 8'h5A, 8'hA5, 1'b1));
        configure(1'b0, 5'b11111);
        send_column(col(8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 1'b0));

        // Recovery with nothing erased passes every share through.
        configure(1'b1, 5'b00000);
        send_column(codeword(8'hA5, 8'h5A, 8'hFF, 5'b00000, 1'b0));
        send_column(make_column(5'b00000, 1'b1));

        for (int a = 0; a < TOTAL_SHARES; a++) begin
            configure(1'b1, t_mask'(1 << a));
            send_column(codeword(8'hFF, 8'h00, 8'h80, t_mask'(1 << a), a[0]));
        end
        for (int a = 0; a < TOTAL_SHARES; a++) begin
            for (int b = a + 1; b < TOTAL_SHARES; b++) begin
                configure(1'b1, t_mask'((1 << a) | (1 << b)));
                send_column(make_column(t_mask'((1 << a) | (1 << b)), 1'b0));
            end
        end

        // Too many erasures: status set, inputs returned untouched.
        configure(1'b1, 5'b00111);
        send_column(make_column(5'b00111, 1'b0));
        configure(1'b1, 5'b11111);
        send_column(col(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));

        total      = 0;
        burst_left = $urandom_range(1, 24);
        while (total < 600) begin
            md  = ($urandom_range(0, 3) != 0);
            msk = pick_mask();
            configure(md, msk);
            items = $urandom_range(10, 30);
            repeat (items) begin
                send_column(make_column(msk, ($urandom_range(0, 4) == 0)));
                total++;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 3) != 0) begin
                        idle_for($urandom_range(1, 8));
                    end
                    burst_left = $urandom_range(1, 24);
                end
            end
        end

        wait_for_drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
